// File: rtl/core/mfde_pkg.sv
// Package for the monochrome frame buffer draw engine.
// Holds the command codes, internal op codes, queue entry type, back-end states and constants.
// No dependencies.
package mfde_pkg;

  localparam int SLOPE_SCALE = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int DVD_W       = 11;
  localparam int DVS_W       = 9;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_CLR    = 3'd1,
    CMD_LINE   = 3'd2,
    CMD_CIRCLE = 3'd3,
    CMD_READ   = 3'd4
  } mfde_cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_LINE_V,
    OP_LINE_H,
    OP_LINE_D,
    OP_CIRCLE,
    OP_READ
  } mfde_op_e;

  typedef struct packed {
    mfde_op_e   op;
    logic       status;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] radius;
    logic [2:0] page_index;
  } mfde_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_K,
    ST_LINE,
    ST_CIRC_TEST,
    ST_CIRC_PLOT,
    ST_CIRC_STEP,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } mfde_state_e;

endpackage

// File: rtl/core/mfde_front.sv
// Command classifier of the draw engine front end.
// Checks bounds, rejects bad commands and sorts lines by direction; uses mfde_pkg.
module mfde_front #(
  parameter int PANEL_WIDTH = 128,
  parameter int PANEL_PAGES = 8
) (
  input  logic [2:0]          command_i,
  input  logic [7:0]          x_start_i,
  input  logic [7:0]          y_start_i,
  input  logic [7:0]          x_end_i,
  input  logic [7:0]          y_end_i,
  input  logic [7:0]          radius_i,
  input  logic [2:0]          page_index_i,
  output mfde_pkg::mfde_cmd_t entry_o
);
  import mfde_pkg::*;

  localparam logic [8:0] WIDTH_9 = 9'(PANEL_WIDTH);
  localparam logic [8:0] ROWS_9  = 9'(PANEL_PAGES * 8);
  localparam logic [4:0] PAGES_5 = 5'(PANEL_PAGES);

  logic pix_ok;
  logic line_bad;
  logic read_ok;

  always_comb begin
    pix_ok   = ({1'b0, x_start_i} < WIDTH_9) && ({1'b0, y_start_i} < ROWS_9);
    line_bad = ({1'b0, x_end_i} > WIDTH_9) || ({1'b0, y_end_i} > ROWS_9) ||
               (x_start_i > x_end_i) || (y_start_i > y_end_i);
    read_ok  = ({1'b0, x_start_i} < WIDTH_9) && ({2'b00, page_index_i} < PAGES_5);

    entry_o.x_start    = x_start_i;
    entry_o.y_start    = y_start_i;
    entry_o.x_end      = x_end_i;
    entry_o.y_end      = y_end_i;
    entry_o.radius     = radius_i;
    entry_o.page_index = page_index_i;
    entry_o.op         = OP_NONE;
    entry_o.status     = 1'b1;

    unique case (mfde_cmd_e'(command_i))
      CMD_SET, CMD_CLR: begin
        if (pix_ok) begin
          entry_o.op     = (mfde_cmd_e'(command_i) == CMD_SET) ? OP_SET : OP_CLR;
          entry_o.status = 1'b0;
        end
      end
      CMD_LINE: begin
        if (!line_bad) begin
          entry_o.status = 1'b0;
          if (x_start_i == x_end_i) begin
            entry_o.op = OP_LINE_V;
          end else if (y_start_i == y_end_i) begin
            entry_o.op = OP_LINE_H;
          end else begin
            entry_o.op = OP_LINE_D;
          end
        end
      end
      CMD_CIRCLE: begin
        entry_o.op     = OP_CIRCLE;
        entry_o.status = 1'b0;
      end
      CMD_READ: begin
        if (read_ok) begin
          entry_o.op     = OP_READ;
          entry_o.status = 1'b0;
        end
      end
      default: begin
        entry_o.op     = OP_NONE;
        entry_o.status = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/mfde_queue.sv
// Short command queue between the front end and the drawing back end.
// Register array with read and write pointers; uses mfde_pkg.
module mfde_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfde_pkg::mfde_cmd_t entry_i,
  input  logic                pop_i,
  output mfde_pkg::mfde_cmd_t entry_o,
  output logic                full_o,
  output logic                empty_o
);
  import mfde_pkg::*;

  mfde_cmd_t              slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/mfde_div.sv
// Restoring divider for the line slope, one quotient bit per cycle.
// Uses the operand widths from mfde_pkg.
module mfde_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mfde_pkg::DVD_W-1:0] dividend_i,
  input  logic [mfde_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [mfde_pkg::DVD_W-1:0] quotient_o
);
  import mfde_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   rem_shift;
  logic             fits;

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;

  always_comb begin
    rem_shift = {rem_q, dvd_q[DVD_W-1]};
    fits      = rem_shift >= {1'b0, dvs_q};
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      cnt_d = CNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], fits};
      rem_d  = fits ? DVS_W'(rem_shift - {1'b0, dvs_q}) : DVS_W'(rem_shift);
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

endmodule

// File: rtl/core/mfde_back.sv
// Drawing back end: frame memory, pixel read-modify-write, line and circle sequencer.
// Uses mfde_pkg and the mfde_div slope divider.
module mfde_back #(
  parameter int PANEL_WIDTH = 128,
  parameter int PANEL_PAGES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfde_pkg::mfde_cmd_t head_i,
  input  logic                head_empty_i,
  output logic                head_pop_o,
  output logic                clearing_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          read_data_o,
  output logic                status_o
);
  import mfde_pkg::*;

  localparam int DEPTH = PANEL_WIDTH * PANEL_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [9:0] WIDTH_S = 10'(PANEL_WIDTH);
  localparam logic signed [9:0] ROWS_S  = 10'(PANEL_PAGES * 8);
  localparam logic [15:0]       RECIP_10 = 16'd52429;

  logic [7:0]         mem_q [DEPTH];
  logic [7:0]         rdata_q;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [7:0]         mem_wdata;

  mfde_state_e        state_q, state_d;
  mfde_state_e        ret_q, ret_d;
  mfde_cmd_t          cmd_q, cmd_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic signed [9:0]  pix_x_q, pix_x_d;
  logic signed [9:0]  pix_y_q, pix_y_d;
  logic               pix_on_q, pix_on_d;
  logic [8:0]         cur_x_q, cur_x_d;
  logic [8:0]         cur_y_q, cur_y_d;
  logic [8:0]         cnt_q, cnt_d;
  logic [7:0]         kq_q, kq_d;
  logic [3:0]         kr_q, kr_d;
  logic [3:0]         frac_q, frac_d;
  logic [8:0]         a_q, a_d;
  logic [7:0]         b_q, b_d;
  logic [17:0]        a2_q, a2_d;
  logic [17:0]        b2_q, b2_d;
  logic [17:0]        r2_q, r2_d;
  logic [2:0]         idx_q, idx_d;
  logic               stat_q, stat_d;
  logic [7:0]         data_q, data_d;
  logic               res_valid_q, res_valid_d;
  logic [7:0]         res_data_q, res_data_d;
  logic               res_status_q, res_status_d;

  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;

  logic               on_panel;
  logic [AW-1:0]      pix_addr;
  logic [7:0]         pix_mask;
  logic [7:0]         head_dy;
  logic [4:0]         frac_sum;
  logic               frac_carry;
  logic [17:0]        a2_next;
  logic signed [9:0]  cx_s, cy_s, a_s, b_s;
  logic               load_res;
  logic [26:0]        k_prod;
  logic [7:0]         k_quo;
  logic [3:0]         k_rem;

  mfde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign clearing_o  = (state_q == ST_CLEAR);
  assign empty_o     = !res_valid_q;
  assign read_data_o = res_data_q;
  assign status_o    = res_status_q;

  always_comb begin
    on_panel = !pix_x_q[9] && (pix_x_q < WIDTH_S) && !pix_y_q[9] && (pix_y_q < ROWS_S);
    pix_addr = AW'(32'(pix_x_q[8:0]) * PANEL_PAGES) + AW'(pix_y_q[8:3]);
    pix_mask = 8'(1) << pix_y_q[2:0];
    head_dy  = head_i.y_end - head_i.y_start;
    frac_sum   = 5'(frac_q) + 5'(kr_q);
    frac_carry = frac_sum >= 5'(SLOPE_SCALE);
    a2_next  = a2_q + 18'({a_q, 1'b0}) + 18'd1;
    cx_s     = $signed({2'b00, cmd_q.x_start});
    cy_s     = $signed({2'b00, cmd_q.y_start});
    a_s      = $signed({1'b0, a_q});
    b_s      = $signed({2'b00, b_q});
    k_prod   = 27'(div_quo) * 27'(RECIP_10);
    k_quo    = k_prod[26:19];
    k_rem    = 4'(div_quo - (11'(k_quo) * 11'(SLOPE_SCALE)));
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_d     = cmd_q;
    clr_d     = clr_q;
    pix_x_d   = pix_x_q;
    pix_y_d   = pix_y_q;
    pix_on_d  = pix_on_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    cnt_d     = cnt_q;
    kq_d      = kq_q;
    kr_d      = kr_q;
    frac_d    = frac_q;
    a_d       = a_q;
    b_d       = b_q;
    a2_d      = a2_q;
    b2_d      = b2_q;
    r2_d      = r2_q;
    idx_d     = idx_q;
    stat_d    = stat_q;
    data_d    = data_q;
    head_pop_o = 1'b0;
    div_start = 1'b0;
    div_dvd   = 11'(head_dy) * 11'(SLOPE_SCALE);
    div_dvs   = 9'(head_i.x_end) - 9'(head_i.x_start);
    mem_addr  = pix_addr;
    mem_we    = 1'b0;
    mem_wdata = pix_on_q ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
    load_res  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!head_empty_i) begin
          head_pop_o = 1'b1;
          cmd_d      = head_i;
          stat_d     = head_i.status;
          data_d     = '0;
          pix_x_d    = $signed({2'b00, head_i.x_start});
          pix_y_d    = $signed({2'b00, head_i.y_start});
          pix_on_d   = 1'b1;
          ret_d      = ST_DONE;
          cur_x_d    = 9'(head_i.x_start);
          cur_y_d    = 9'(head_i.y_start);
          frac_d     = '0;
          unique case (head_i.op)
            OP_SET, OP_CLR: begin
              pix_on_d = (head_i.op == OP_SET);
              state_d  = ST_PIX_RD;
            end
            OP_LINE_V: begin
              cnt_d   = 9'(head_dy);
              state_d = ST_LINE;
            end
            OP_LINE_H: begin
              cnt_d   = 9'(head_i.x_end) - 9'(head_i.x_start);
              state_d = ST_LINE;
            end
            OP_LINE_D: begin
              cnt_d     = 9'(head_i.x_end) - 9'(head_i.x_start);
              div_start = 1'b1;
              state_d   = ST_DIV_K;
            end
            OP_CIRCLE: begin
              a_d  = '0;
              b_d  = head_i.radius;
              a2_d = '0;
              r2_d = 18'(head_i.radius) * 18'(head_i.radius);
              b2_d = 18'(head_i.radius) * 18'(head_i.radius);
              if (head_i.radius == '0) begin
                state_d = ST_PIX_RD;
              end else begin
                state_d = ST_CIRC_TEST;
              end
            end
            OP_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV_K: begin
        if (div_done) begin
          kq_d    = k_quo;
          kr_d    = k_rem;
          state_d = ST_LINE;
        end
      end
      ST_LINE: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          pix_x_d = $signed({1'b0, cur_x_q});
          pix_y_d = $signed({1'b0, cur_y_q});
          cnt_d   = cnt_q - 1'b1;
          ret_d   = ST_LINE;
          state_d = ST_PIX_RD;
          if (cmd_q.op == OP_LINE_V) begin
            cur_y_d = cur_y_q + 1'b1;
          end else if (cmd_q.op == OP_LINE_H) begin
            cur_x_d = cur_x_q + 1'b1;
          end else begin
            cur_x_d = cur_x_q + 1'b1;
            cur_y_d = cur_y_q + 9'(kq_q) + 9'(frac_carry);
            frac_d  = frac_carry ? 4'(frac_sum - 5'(SLOPE_SCALE)) : 4'(frac_sum);
          end
        end
      end
      ST_CIRC_TEST: begin
        idx_d = '0;
        if ({b2_q, 1'b0} >= {1'b0, r2_q}) begin
          state_d = ST_CIRC_PLOT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CIRC_PLOT: begin
        case (idx_q)
          3'd0: begin pix_x_d = cx_s + a_s; pix_y_d = cy_s - b_s; end
          3'd1: begin pix_x_d = cx_s - a_s; pix_y_d = cy_s - b_s; end
          3'd2: begin pix_x_d = cx_s - a_s; pix_y_d = cy_s + b_s; end
          3'd3: begin pix_x_d = cx_s + a_s; pix_y_d = cy_s + b_s; end
          3'd4: begin pix_x_d = cx_s + b_s; pix_y_d = cy_s + a_s; end
          3'd5: begin pix_x_d = cx_s + b_s; pix_y_d = cy_s - a_s; end
          3'd6: begin pix_x_d = cx_s - b_s; pix_y_d = cy_s - a_s; end
          default: begin pix_x_d = cx_s - b_s; pix_y_d = cy_s + a_s; end
        endcase
        idx_d   = idx_q + 1'b1;
        ret_d   = (idx_q == 3'd7) ? ST_CIRC_STEP : ST_CIRC_PLOT;
        state_d = ST_PIX_RD;
      end
      ST_CIRC_STEP: begin
        if ((a2_next + b2_q) > r2_q) begin
          b_d  = b_q - 1'b1;
          b2_d = b2_q - 18'({b_q, 1'b0}) + 18'd1;
        end else begin
          a_d  = a_q + 1'b1;
          a2_d = a2_next;
        end
        state_d = ST_CIRC_TEST;
      end
      ST_PIX_RD: begin
        state_d = on_panel ? ST_PIX_WR : ret_q;
      end
      ST_PIX_WR: begin
        mem_we  = 1'b1;
        state_d = ret_q;
      end
      ST_READ: begin
        mem_addr = AW'(32'(cmd_q.x_start) * PANEL_PAGES) + AW'(cmd_q.page_index);
        state_d  = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        data_d  = rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_q || pop_i) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_valid_d  = load_res || (res_valid_q && !pop_i);
    res_data_d   = load_res ? data_q : res_data_q;
    res_status_d = load_res ? stat_q : res_status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      ret_q        <= ST_DONE;
      clr_q        <= '0;
      res_valid_q  <= 1'b0;
      res_data_q   <= '0;
      res_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      clr_q        <= clr_d;
      res_valid_q  <= res_valid_d;
      res_data_q   <= res_data_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
    pix_on_q <= pix_on_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    cnt_q    <= cnt_d;
    kq_q     <= kq_d;
    kr_q     <= kr_d;
    frac_q   <= frac_d;
    a_q      <= a_d;
    b_q      <= b_d;
    a2_q     <= a2_d;
    b2_q     <= b2_d;
    r2_q     <= r2_d;
    idx_q    <= idx_d;
    stat_q   <= stat_d;
    data_q   <= data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

endmodule

// File: rtl/core/mono_framebuffer_draw_engine.sv
// Monochrome frame buffer draw engine, top level; uses mfde_pkg and the mfde_* modules.
// Set or clear pixel goes from queue head through pixel read and pixel write to done;
// read byte goes through read and read wait. Each line pixel goes through line, pixel
// read and pixel write, after the slope division when diagonal. Circles plot eight
// points per step, each through plot, pixel read and pixel write, then step and test.
// After reset a clearing pass writes every frame byte, during which full stays high.
module mono_framebuffer_draw_engine #(
  parameter int PANEL_WIDTH = 128,
  parameter int PANEL_PAGES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] command_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [7:0] radius_i,
  input  logic [2:0] page_index_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data_o,
  output logic       status_o
);
  import mfde_pkg::*;

  mfde_cmd_t entry_in;
  mfde_cmd_t entry_head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      clearing;

  assign full = q_full || clearing;

  mfde_front #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PANEL_PAGES(PANEL_PAGES)
  ) u_front (
    .command_i   (command_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .radius_i    (radius_i),
    .page_index_i(page_index_i),
    .entry_o     (entry_in)
  );

  mfde_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !clearing),
    .entry_i(entry_in),
    .pop_i  (q_pop),
    .entry_o(entry_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  mfde_back #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PANEL_PAGES(PANEL_PAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (entry_head),
    .head_empty_i(q_empty),
    .head_pop_o  (q_pop),
    .clearing_o  (clearing),
    .pop_i       (pop),
    .empty_o     (empty),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the monochrome frame buffer draw engine.
// It predicts every result from its own model of the frame store and compares each transfer.
// It depends on mfde_pkg and mono_framebuffer_draw_engine.
module testbench;
  import mfde_pkg::*;

  localparam int WIDTH = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] xs, ys, xe, ye, rad;
    logic [2:0] pg;
    int         gap;
    bit         drain;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       status;
  } draw_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [2:0] command_i = '0;
  logic [7:0] x_start_i = '0, y_start_i = '0, x_end_i = '0, y_end_i = '0, radius_i = '0;
  logic [2:0] page_index_i = '0;
  logic [7:0] read_data_o;
  logic status_o;

  draw_cmd_t pending_cmds[$];
  draw_result_t expected_results[$];
  logic [7:0] shadow_frame[WIDTH * PAGES];
  int error_count = 0;
  int results_seen = 0;
  int items_made = 0;
  bit no_gaps;

  mono_framebuffer_draw_engine u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= WIDTH || y < 0 || y >= ROWS) return;
    idx = x * PAGES + y / 8;
    if (on) shadow_frame[idx][y % 8] = 1'b1;
    else shadow_frame[idx][y % 8] = 1'b0;
  endfunction

  function automatic logic predict_line(int x1, int y1, int x2, int y2);
    int k;
    if (x2 > WIDTH || y2 > ROWS || x1 > x2 || y1 > y2) return 1'b1;
    if (x1 == x2) begin
      for (int i = 0; i < y2 - y1; i++) plot(x1, y1 + i, 1'b1);
    end else if (y1 == y2) begin
      for (int i = 0; i < x2 - x1; i++) plot(x1 + i, y1, 1'b1);
    end else begin
      k = (y2 - y1) * 10 / (x2 - x1);
      for (int i = 0; i < x2 - x1; i++) plot(x1 + i, y1 + i * k / 10, 1'b1);
    end
    return 1'b0;
  endfunction

  function automatic void predict_circle(int cx, int cy, int r);
    int a, b;
    a = 0;
    b = r;
    if (r == 0) begin
      plot(cx, cy, 1'b1);
      return;
    end
    while (2 * b * b >= r * r) begin
      plot(cx + a, cy - b, 1'b1);
      plot(cx - a, cy - b, 1'b1);
      plot(cx - a, cy + b, 1'b1);
      plot(cx + a, cy + b, 1'b1);
      plot(cx + b, cy + a, 1'b1);
      plot(cx + b, cy - a, 1'b1);
      plot(cx - b, cy - a, 1'b1);
      plot(cx - b, cy + a, 1'b1);
      a++;
      if (a * a + b * b - r * r > 0) begin
        a--;
        b--;
      end
    end
  endfunction

  function automatic draw_result_t apply_command(draw_cmd_t c);
    draw_result_t res;
    res.data = '0;
    res.status = 1'b0;
    case (c.cmd)
      CMD_SET, CMD_CLR: begin
        if (c.xs < WIDTH && c.ys < ROWS) plot(c.xs, c.ys, c.cmd == CMD_SET);
        else res.status = 1'b1;
      end
      CMD_LINE: res.status = predict_line(c.xs, c.ys, c.xe, c.ye);
      CMD_CIRCLE: predict_circle(c.xs, c.ys, c.rad);
      CMD_READ: begin
        if (c.xs < WIDTH && c.pg < PAGES) res.data = shadow_frame[c.xs * PAGES + c.pg];
        else res.status = 1'b1;
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  function automatic void add_cmd(logic [2:0] cmd, int xs, int ys, int xe, int ye, int rad,
                                  int pg, bit drain = 1'b0);
    draw_cmd_t c;
    no_gaps = ((items_made / 150) % 3) == 0;
    c.cmd = cmd;
    c.xs = xs;
    c.ys = ys;
    c.xe = xe;
    c.ye = ye;
    c.rad = rad;
    c.pg = pg;
    c.gap = no_gaps ? 0 : $urandom_range(0, 13);
    c.drain = drain;
    pending_cmds.push_back(c);
    items_made++;
  endfunction

  function automatic int pick_col();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, WIDTH - 1);
  endfunction

  function automatic int pick_row();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ROWS - 1);
  endfunction

  function automatic void add_random_cmd(bit drain);
    int sel, x1, x2, y1, y2, shape;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      add_cmd(CMD_SET, pick_col(), pick_row(), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 7), drain);
    end else if (sel < 30) begin
      add_cmd(CMD_CLR, pick_col(), pick_row(), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 7), drain);
    end else if (sel < 55) begin
      add_cmd(CMD_READ, pick_col(), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 7), drain);
    end else if (sel < 75) begin
      x2 = $urandom_range(0, WIDTH);
      x1 = $urandom_range(0, x2);
      y2 = $urandom_range(0, ROWS);
      y1 = $urandom_range(0, y2);
      shape = $urandom_range(0, 2);
      if (shape == 0) x2 = x1;
      else if (shape == 1) y2 = y1;
      add_cmd(CMD_LINE, x1, y1, x2, y2, $urandom_range(0, 255), $urandom_range(0, 7), drain);
    end else if (sel < 88) begin
      add_cmd(CMD_CIRCLE, pick_col(), pick_row(), $urandom_range(0, 255), $urandom_range(0, 255),
              ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20),
              $urandom_range(0, 7), drain);
    end else begin
      sel = $urandom_range(0, 7);
      add_cmd(sel[2:0], $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255),
              (sel == CMD_CIRCLE) ? $urandom_range(0, 40) : $urandom_range(0, 255),
              $urandom_range(0, 7), drain);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_cmd_t nxt;
    logic next_push;
    int gap_left;
    if (!rst_ni) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      next_push = push;
      if (push && !full) begin
        expected_results.push_back(apply_command(pending_cmds.pop_front()));
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_results.size() > 0)) begin
          nxt = pending_cmds[0];
          command_i <= nxt.cmd;
          x_start_i <= nxt.xs;
          y_start_i <= nxt.ys;
          x_end_i <= nxt.xe;
          y_end_i <= nxt.ye;
          radius_i <= nxt.rad;
          page_index_i <= nxt.pg;
          gap_left = (pending_cmds.size() > 1) ? pending_cmds[1].gap : 0;
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t want;
    int stall_left;
    int hold_left;
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("Result transfer with no command outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (read_data_o !== want.data) begin
            $error("read_data: expected %0h, got %0h", want.data, read_data_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, status_o);
            error_count++;
          end
        end
        results_seen++;
        if (results_seen == 500) hold_left = 400;
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if ((results_seen / 200) % 3 == 1) stall_left = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < WIDTH * PAGES; i++) shadow_frame[i] = '0;
    add_cmd(CMD_SET, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_SET, WIDTH - 1, ROWS - 1, 255, 255, 255, 7);
    add_cmd(CMD_SET, WIDTH, 0, 0, 0, 0, 0);
    add_cmd(CMD_CLR, 0, ROWS, 0, 0, 0, 0);
    add_cmd(CMD_SET, 255, 255, 0, 0, 0, 0);
    add_cmd(CMD_READ, WIDTH - 1, 0, 0, 0, 0, 7);
    add_cmd(CMD_CLR, WIDTH - 1, ROWS - 1, 0, 0, 0, 0);
    add_cmd(CMD_READ, WIDTH - 1, 0, 0, 0, 0, 7);
    add_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_LINE, 5, 3, 5, 20, 0, 0);
    add_cmd(CMD_LINE, 0, 63, WIDTH, ROWS - 1, 0, 0);
    add_cmd(CMD_LINE, 10, 10, 10, 10, 0, 0);
    add_cmd(CMD_LINE, 0, 0, WIDTH, ROWS, 0, 0);
    add_cmd(CMD_LINE, 20, 5, 30, 40, 0, 0);
    add_cmd(CMD_LINE, 0, 0, WIDTH + 1, 4, 0, 0);
    add_cmd(CMD_LINE, 0, 0, 4, ROWS + 1, 0, 0);
    add_cmd(CMD_LINE, 9, 0, 8, 4, 0, 0);
    add_cmd(CMD_LINE, 0, 9, 4, 8, 0, 0);
    add_cmd(CMD_CIRCLE, 40, 30, 0, 0, 0, 0);
    add_cmd(CMD_CIRCLE, 2, 3, 0, 0, 12, 0);
    add_cmd(CMD_CIRCLE, 64, 32, 0, 0, 255, 0);
    add_cmd(CMD_READ, 255, 0, 0, 0, 0, 7);
    add_cmd(CMD_READ, 64, 0, 0, 0, 0, 4);
    add_cmd(CMD_RESERVED_LO, 1, 1, 1, 1, 1, 1);
    add_cmd(CMD_RESERVED_HI, 255, 255, 255, 255, 255, 7);
    for (int i = 0; i < 1700; i++) add_random_cmd(i == 800);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #600_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: mono_framebuffer_draw_engine.f
rtl/core/mfde_pkg.sv
rtl/core/mfde_front.sv
rtl/core/mfde_queue.sv
rtl/core/mfde_div.sv
rtl/core/mfde_back.sv
rtl/core/mono_framebuffer_draw_engine.sv
tb/testbench.sv
